// ===== rtl/core/utfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_pkg
// Types and constants shared by the trigger and frame controller core.
// ----------------------------------------------------------------------------
package utfc_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ENABLE       = 2'd0;
   localparam logic [1:0] REG_PULSE_MS     = 2'd1;
   localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_MS   = 2'd3;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_BYTE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] START_NONE      = 2'd0;
   localparam logic [1:0] START_ACCEPTED  = 2'd1;
   localparam logic [1:0] START_BUSY      = 2'd2;
   localparam logic [1:0] START_NOT_READY = 2'd3;

   localparam logic [7:0]  FRAME_HEAD = 8'hFF;
   localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

   localparam logic [15:0] PULSE_MS_RESET     = 16'd1;
   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd100;
   localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd100;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_WAITING  = 3'd1,
      MODE_COMPLETE = 3'd2,
      MODE_TIMEOUT  = 3'd3,
      MODE_ERROR    = 3'd4
   } mode_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  start_status;
      logic [2:0]  state_code;
      logic        trigger_level;
      logic [15:0] distance_value;
      logic        distance_valid;
      logic [31:0] age_value;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic        trigger_out;
      logic        release_pending;
      logic        ever_triggered;
      logic [31:0] since_trigger;
      logic [1:0]  byte_index;
      logic [15:0] last_distance;
      logic        have_valid;
      logic [31:0] valid_age;
   } core_state_type;

   typedef logic [2:0][7:0] frame_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] pulse_ms;
      logic [15:0] min_interval_ms;
      logic [15:0] timeout_ms;
   } cfg_type;

   localparam core_state_type STATE_RESET = '{
      mode:            MODE_IDLE,
      trigger_out:     1'b1,
      release_pending: 1'b0,
      ever_triggered:  1'b0,
      since_trigger:   32'd0,
      byte_index:      2'd0,
      last_distance:   16'd0,
      have_valid:      1'b0,
      valid_age:       32'd0
   };

endpackage
`default_nettype wire

// ===== rtl/core/utfc_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_step
// Next state and result for one item: tick, start request, byte or error.
// ----------------------------------------------------------------------------
module utfc_step (
   input  wire  utfc_pkg::cfg_type        cfg,
   input  wire  utfc_pkg::core_state_type cur_state,
   input  wire  utfc_pkg::frame_type      cur_frame,
   input  wire  utfc_pkg::req_type        req,
   output utfc_pkg::core_state_type       nxt_state,
   output utfc_pkg::frame_type            nxt_frame,
   output utfc_pkg::rsp_type              rsp
);

   logic       waiting;
   logic [9:0] sum_wide;
   logic [1:0] status;

   assign waiting  = cfg.enable && (cur_state.mode == utfc_pkg::MODE_WAITING);
   assign sum_wide = {2'b00, cur_frame[0]} + {2'b00, cur_frame[1]} + {2'b00, cur_frame[2]};

   always_comb begin
      nxt_state = cur_state;
      nxt_frame = cur_frame;
      status    = utfc_pkg::START_NONE;

      case (req.kind)
         utfc_pkg::KIND_TICK: begin
            if (cur_state.since_trigger != utfc_pkg::SAT32) begin
               nxt_state.since_trigger = cur_state.since_trigger + 32'd1;
            end
            if (cur_state.have_valid && cur_state.valid_age != utfc_pkg::SAT32) begin
               nxt_state.valid_age = cur_state.valid_age + 32'd1;
            end
         end
         utfc_pkg::KIND_START: begin
            if (!cfg.enable) begin
               status = utfc_pkg::START_NOT_READY;
            end else if (cur_state.mode == utfc_pkg::MODE_WAITING) begin
               status = utfc_pkg::START_BUSY;
            end else if (cur_state.ever_triggered &&
                         cur_state.since_trigger < {16'd0, cfg.min_interval_ms}) begin
               status = utfc_pkg::START_BUSY;
            end else begin
               status                    = utfc_pkg::START_ACCEPTED;
               nxt_state.byte_index      = 2'd0;
               nxt_state.ever_triggered  = 1'b1;
               nxt_state.release_pending = 1'b1;
               nxt_state.trigger_out     = 1'b0;
               nxt_state.since_trigger   = 32'd0;
               nxt_state.mode            = utfc_pkg::MODE_WAITING;
            end
         end
         utfc_pkg::KIND_BYTE: begin
            if (waiting) begin
               if (cur_state.byte_index != 2'd3) begin
                  nxt_frame[cur_state.byte_index] = req.data_byte;
                  nxt_state.byte_index = cur_state.byte_index + 2'd1;
               end else begin
                  nxt_state.trigger_out     = 1'b1;
                  nxt_state.release_pending = 1'b0;
                  nxt_state.byte_index      = 2'd0;
                  if (cur_frame[0] == utfc_pkg::FRAME_HEAD && req.data_byte == sum_wide[7:0]) begin
                     nxt_state.last_distance = {cur_frame[1], cur_frame[2]};
                     nxt_state.have_valid    = 1'b1;
                     nxt_state.valid_age     = 32'd0;
                     nxt_state.mode          = utfc_pkg::MODE_COMPLETE;
                  end else begin
                     nxt_state.mode = utfc_pkg::MODE_ERROR;
                  end
               end
            end
         end
         default: begin
            if (waiting) begin
               nxt_state.trigger_out     = 1'b1;
               nxt_state.release_pending = 1'b0;
               nxt_state.byte_index      = 2'd0;
               nxt_state.mode            = utfc_pkg::MODE_ERROR;
            end
         end
      endcase

      // pulse release and timeout checks after the item
      if (cfg.enable && nxt_state.mode == utfc_pkg::MODE_WAITING) begin
         if (nxt_state.release_pending &&
             nxt_state.since_trigger >= {16'd0, cfg.pulse_ms}) begin
            nxt_state.trigger_out     = 1'b1;
            nxt_state.release_pending = 1'b0;
         end
         if (nxt_state.since_trigger >= {16'd0, cfg.timeout_ms}) begin
            nxt_state.trigger_out     = 1'b1;
            nxt_state.release_pending = 1'b0;
            nxt_state.byte_index      = 2'd0;
            nxt_state.mode            = utfc_pkg::MODE_TIMEOUT;
         end
      end

      rsp.start_status   = status;
      rsp.state_code     = nxt_state.mode;
      rsp.trigger_level  = nxt_state.trigger_out;
      rsp.distance_value = nxt_state.last_distance;
      rsp.distance_valid = nxt_state.have_valid;
      rsp.age_value      = nxt_state.have_valid ? nxt_state.valid_age : 32'd0;
   end

endmodule
`default_nettype wire

// ===== rtl/core/utfc_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_outbuf
// Result register with a one-entry skid stage behind it.
// ----------------------------------------------------------------------------
module utfc_outbuf (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  wire  utfc_pkg::rsp_type in_data,
   output logic                    in_stall,
   output logic                    out_valid,
   input  wire                     out_stall,
   output utfc_pkg::rsp_type       out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   utfc_pkg::rsp_type out_data_ff, out_data_in;
   utfc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_free;

   assign out_free  = !out_valid_ff || !out_stall;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/ultrasonic_trigger_frame_controller_core.sv =====
`default_nettype none
// The result of an accepted item is registered before it appears on rsp_data.
// Throughput: one item per cycle; the result register has a one-entry skid
// stage, so req_stall rises only when both hold an unclaimed result.
// Reset (synchronous): state, config and valid flags reset; channels empty.
// ----------------------------------------------------------------------------
// ultrasonic_trigger_frame_controller_core
// Trigger pulse, frame check and timing for a pulse-triggered range sensor.
// ----------------------------------------------------------------------------
module ultrasonic_trigger_frame_controller_core (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  utfc_pkg::req_type                  req_data,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output utfc_pkg::rsp_type                        rsp_data,
   input  wire                                      csr_psel,
   input  wire                                      csr_penable,
   input  wire                                      csr_pwrite,
   input  wire  [utfc_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  wire  [utfc_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [utfc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   utfc_pkg::cfg_type        cfg_ff, cfg_in;
   utfc_pkg::core_state_type state_ff, state_in, step_state;
   utfc_pkg::frame_type      frame_ff, frame_in, step_frame;
   utfc_pkg::rsp_type        step_rsp;
   logic                     req_accept;
   logic                     csr_write;
   logic [1:0]               csr_index;

   assign req_accept = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      unique case (csr_index)
         utfc_pkg::REG_ENABLE:       csr_prdata = {31'd0, cfg_ff.enable};
         utfc_pkg::REG_PULSE_MS:     csr_prdata = {16'd0, cfg_ff.pulse_ms};
         utfc_pkg::REG_MIN_INTERVAL: csr_prdata = {16'd0, cfg_ff.min_interval_ms};
         utfc_pkg::REG_TIMEOUT_MS:   csr_prdata = {16'd0, cfg_ff.timeout_ms};
         default:                    csr_prdata = '0;
      endcase
   end

   utfc_step u_step (
      .cfg       (cfg_ff),
      .cur_state (state_ff),
      .cur_frame (frame_ff),
      .req       (req_data),
      .nxt_state (step_state),
      .nxt_frame (step_frame),
      .rsp       (step_rsp)
   );

   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      frame_in = frame_ff;
      if (csr_write) begin
         unique case (csr_index)
            utfc_pkg::REG_ENABLE: begin
               cfg_in.enable = csr_pwdata[0];
               if (csr_pwdata[0] && !cfg_ff.enable) begin
                  state_in = utfc_pkg::STATE_RESET;
               end else if (!csr_pwdata[0] && cfg_ff.enable) begin
                  state_in.trigger_out     = 1'b1;
                  state_in.release_pending = 1'b0;
                  state_in.byte_index      = 2'd0;
                  state_in.mode            = utfc_pkg::MODE_IDLE;
                  state_in.have_valid      = 1'b0;
                  state_in.valid_age       = 32'd0;
               end
            end
            utfc_pkg::REG_PULSE_MS:     cfg_in.pulse_ms        = csr_pwdata[15:0];
            utfc_pkg::REG_MIN_INTERVAL: cfg_in.min_interval_ms = csr_pwdata[15:0];
            utfc_pkg::REG_TIMEOUT_MS:   cfg_in.timeout_ms      = csr_pwdata[15:0];
            default: ;
         endcase
      end else if (req_accept) begin
         state_in = step_state;
         frame_in = step_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b0;
         cfg_ff.pulse_ms        <= utfc_pkg::PULSE_MS_RESET;
         cfg_ff.min_interval_ms <= utfc_pkg::MIN_INTERVAL_RESET;
         cfg_ff.timeout_ms      <= utfc_pkg::TIMEOUT_MS_RESET;
         state_ff               <= utfc_pkg::STATE_RESET;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   // frame bytes are always written before they are read
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   utfc_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (step_rsp),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/core/utfc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utfc_checker
// Port-level checks on the trigger and frame controller core.
// ----------------------------------------------------------------------------
module utfc_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire utfc_pkg::rsp_type rsp_data
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result channel not empty after reset");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   a_accept_starts_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.start_status == utfc_pkg::START_ACCEPTED) |->
      (rsp_data.state_code == utfc_pkg::MODE_WAITING ||
       rsp_data.state_code == utfc_pkg::MODE_TIMEOUT))
      else $error("accepted start without waiting state");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind ultrasonic_trigger_frame_controller_core utfc_checker u_utfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
